// ===== src/edd_pkg.sv =====
`timescale 1ns / 1ps

package edd_pkg;

	// Fixed-point layout of the average.
	localparam int ADC_BITS    = 12;
	localparam int FRAC_BITS   = 16;
	localparam int AVG_W       = ADC_BITS + FRAC_BITS;
	localparam int ALPHA_BITS  = 16;
	localparam int MARGIN_BITS = 12;
	localparam int CNT_W       = 16;
	localparam int TOTAL_W     = 48;

	// The margin compares add a sample code and a margin code, then append the fraction.
	localparam int SUM_INT_W = ((ADC_BITS > MARGIN_BITS) ? ADC_BITS : MARGIN_BITS) + 1;
	localparam int SUM_W     = SUM_INT_W + FRAC_BITS;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA          = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DIP_MARGIN     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_MARGIN = CFG_IDX_W'(2);

	localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET          = ALPHA_BITS'(66);
	localparam logic [MARGIN_BITS-1:0] DIP_MARGIN_RESET     = MARGIN_BITS'(228);
	localparam logic [MARGIN_BITS-1:0] RECOVER_MARGIN_RESET = MARGIN_BITS'(159);

	// Operation codes of an input item.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef struct packed {
		logic                op;
		logic [ADC_BITS-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [AVG_W-1:0]   average_q;
		logic               in_dip;
		logic [CNT_W-1:0]   window_dips;
		logic [CNT_W-1:0]   last_window_dips;
		logic [CNT_W-1:0]   window_samples;
		logic [TOTAL_W-1:0] total_samples;
	} result_t;

	typedef struct packed {
		logic [ALPHA_BITS-1:0]  alpha;
		logic [MARGIN_BITS-1:0] dip_margin;
		logic [MARGIN_BITS-1:0] recover_margin;
	} cfg_t;

endpackage

// ===== src/ema_dip_detector.sv =====
`timescale 1ns / 1ps

// Light-sensor dip detector with an exponential moving average.
// Input channel (item_valid, item_stall, item): each transaction is either an ADC
// sample or a window tick. Output channel (result_valid, result_stall, result):
// exactly one result transaction follows every input transaction, in order, and
// carries the state after that input was applied.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 is
// alpha, 1 the dip margin, 2 the recover margin; other indexes are ignored.
// cfg_ready is always high. Write only while no transaction is in flight.
// An accepted item passes through the input register and then the result register
// on its way to the output.
// Throughput: one item per cycle unless stalled. The average feeds back into the next
// item through one 17 x 29 bit signed multiply and an add, which sets the clock.
// When the receiver stalls, the result register holds its transaction and the input
// register still takes one more item; only when both are full does item_stall rise.
// Reset clears the average, the dip flag and every counter, and loads the default
// alpha and margins; both channels come out of reset empty.
module ema_dip_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  edd_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output edd_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [edd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [edd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import edd_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_q;
	logic    result_valid_q;
	result_t next_result;
	logic    advance;
	logic    fire;

	edd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The result register can take a new transaction when it is empty or being drained.
	assign advance    = !result_valid_q || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	// Input register: refills whenever it is empty or its item moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// State registers and the update logic live in the core; they commit on fire.
	edd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.cfg         (cfg),
		.next_result (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The input side only backs up when both registers hold a transaction.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid_q && result_stall))
		else $error("input stalled while a register was free");

	// A tick clears the window counters in the result it produces.
	a_tick_clears_window: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (item_s1.op == OP_TICK)) |=>
		((result_q.window_dips == '0) && (result_q.window_samples == '0)))
		else $error("window counters not cleared by a tick");

	// Each sample starts at most one dip, so dips never outnumber samples in a window.
	a_dips_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.window_dips <= result_q.window_samples))
		else $error("window dip count exceeds window sample count");

endmodule

// ===== src/edd_cfg.sv =====
`timescale 1ns / 1ps

module edd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [edd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [edd_pkg::CFG_DATA_W-1:0] cfg_data,
	output edd_pkg::cfg_t                  cfg
);
	import edd_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken; an index past the last register is dropped.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha          <= ALPHA_RESET;
			cfg_q.dip_margin     <= DIP_MARGIN_RESET;
			cfg_q.recover_margin <= RECOVER_MARGIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ALPHA: begin
					cfg_q.alpha <= cfg_data[ALPHA_BITS-1:0];
				end
				CFG_DIP_MARGIN: begin
					cfg_q.dip_margin <= cfg_data[MARGIN_BITS-1:0];
				end
				CFG_RECOVER_MARGIN: begin
					cfg_q.recover_margin <= cfg_data[MARGIN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/edd_core.sv =====
`timescale 1ns / 1ps

module edd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  edd_pkg::item_t   item,
	input  edd_pkg::cfg_t    cfg,
	output edd_pkg::result_t next_result
);
	import edd_pkg::*;

	logic [AVG_W-1:0]   avg_q;
	logic               dip_q;
	logic [CNT_W-1:0]   dips_q;
	logic [CNT_W-1:0]   latched_q;
	logic [CNT_W-1:0]   samples_q;
	logic [TOTAL_W-1:0] total_q;

	logic [AVG_W-1:0]                  s_fix;
	logic [SUM_W-1:0]                  avg_ext;
	logic [SUM_INT_W-1:0]              rec_int;
	logic [SUM_INT_W-1:0]              dip_int;
	logic                              recovered;
	logic                              flag_mid;
	logic                              dip_start;
	logic signed [AVG_W:0]             diff;
	logic signed [AVG_W+ALPHA_BITS+1:0] prod;
	logic signed [AVG_W+1:0]           step;
	logic signed [AVG_W+1:0]           avg_sum;
	logic [AVG_W-1:0]                  avg_new;

	logic [AVG_W-1:0]   avg_d;
	logic               dip_d;
	logic [CNT_W-1:0]   dips_d;
	logic [CNT_W-1:0]   latched_d;
	logic [CNT_W-1:0]   samples_d;
	logic [TOTAL_W-1:0] total_d;

	assign s_fix   = {item.sample, {FRAC_BITS{1'b0}}};
	assign avg_ext = SUM_W'(avg_q);

	// Compare sample + margin against the old average, so nothing goes negative.
	assign rec_int = SUM_INT_W'(item.sample) + SUM_INT_W'(cfg.recover_margin);
	assign dip_int = SUM_INT_W'(item.sample) + SUM_INT_W'(cfg.dip_margin);

	assign recovered = dip_q && ({rec_int, {FRAC_BITS{1'b0}}} >= avg_ext);
	assign flag_mid  = dip_q && !recovered;
	assign dip_start = !flag_mid && ({dip_int, {FRAC_BITS{1'b0}}} < avg_ext);

	// Average step; taking the upper product bits of a signed value floors it.
	assign diff    = $signed({1'b0, s_fix}) - $signed({1'b0, avg_q});
	assign prod    = diff * $signed({1'b0, cfg.alpha});
	assign step    = $signed(prod[AVG_W+ALPHA_BITS+1:ALPHA_BITS]);
	assign avg_sum = $signed({2'b00, avg_q}) + step;

	always_comb begin
		if (avg_sum[AVG_W+1]) begin
			avg_new = '0;
		end else if (avg_sum[AVG_W]) begin
			avg_new = '1;
		end else begin
			avg_new = avg_sum[AVG_W-1:0];
		end
	end

	always_comb begin
		avg_d     = avg_q;
		dip_d     = dip_q;
		dips_d    = dips_q;
		latched_d = latched_q;
		samples_d = samples_q;
		total_d   = total_q;
		if (item.op == OP_TICK) begin
			latched_d = dips_q;
			dips_d    = '0;
			samples_d = '0;
		end else begin
			avg_d = avg_new;
			dip_d = flag_mid || dip_start;
			if (dip_start && (dips_q != '1)) begin
				dips_d = dips_q + 1'b1;
			end
			if (samples_q != '1) begin
				samples_d = samples_q + 1'b1;
			end
			if (total_q != '1) begin
				total_d = total_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q     <= '0;
			dip_q     <= 1'b0;
			dips_q    <= '0;
			latched_q <= '0;
			samples_q <= '0;
			total_q   <= '0;
		end else if (fire) begin
			avg_q     <= avg_d;
			dip_q     <= dip_d;
			dips_q    <= dips_d;
			latched_q <= latched_d;
			samples_q <= samples_d;
			total_q   <= total_d;
		end
	end

	assign next_result.average_q        = avg_d;
	assign next_result.in_dip           = dip_d;
	assign next_result.window_dips      = dips_d;
	assign next_result.last_window_dips = latched_d;
	assign next_result.window_samples   = samples_d;
	assign next_result.total_samples    = total_d;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the EMA dip detector.
// A driver process feeds input transactions from a backlog queue, a monitor process
// predicts the status that each accepted transaction must produce and checks every
// result transaction against it in order. The initial block runs the phases: a short
// directed part, a few random parts under different idling, and a closing run of
// full-scale swings where every pair of samples starts a dip.
module tb;

	import edd_pkg::*;

	// Index 3 is not decoded by the block; a write to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

	localparam int LIMIT_CYCLES = 1000000;
	localparam int HOLD_CYCLES  = 50;
	localparam int DIP_PAIRS    = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ema_dip_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Our own copy of the detector: configuration and state.
	logic [ALPHA_BITS-1:0] alpha_w = ALPHA_RESET;
	logic [MARGIN_BITS-1:0] dip_margin_w = DIP_MARGIN_RESET;
	logic [MARGIN_BITS-1:0] recover_margin_w = RECOVER_MARGIN_RESET;
	logic [AVG_W-1:0] avg_q16 = '0;
	logic dip_active = 1'b0;
	logic [CNT_W-1:0] dips_in_window = '0;
	logic [CNT_W-1:0] dips_latched = '0;
	logic [CNT_W-1:0] samples_in_window = '0;
	logic [TOTAL_W-1:0] samples_total = '0;

	item_t item_backlog[$];
	item_t batch[$];
	result_t due_status[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	logic item_taken = 1'b0;
	int queued_cnt = 0;
	int accepted_cnt = 0;
	int fail_cnt = 0;
	int cycle_cnt = 0;

	// Applies one input transaction to the local state and queues the status that the
	// block has to report for it. The average step is floored, which an arithmetic
	// shift of the signed product gives directly.
	task automatic predict_status(input item_t it);
		longint s;
		longint a;
		longint nxt;
		result_t st;
		if (it.op == OP_TICK) begin
			dips_latched = dips_in_window;
			dips_in_window = '0;
			samples_in_window = '0;
		end else begin
			s = longint'(it.sample) <<< FRAC_BITS;
			a = longint'(avg_q16);
			// Hysteresis: the recover check runs first, so a sample may end one dip
			// and start the next one in the same transaction.
			if (dip_active && s >= a - (longint'(recover_margin_w) <<< FRAC_BITS))
				dip_active = 1'b0;
			if (!dip_active && s < a - (longint'(dip_margin_w) <<< FRAC_BITS)) begin
				dip_active = 1'b1;
				if (dips_in_window != '1)
					dips_in_window = dips_in_window + CNT_W'(1);
			end
			if (samples_in_window != '1)
				samples_in_window = samples_in_window + CNT_W'(1);
			if (samples_total != '1)
				samples_total = samples_total + TOTAL_W'(1);
			nxt = a + ((longint'(alpha_w) * (s - a)) >>> ALPHA_BITS);
			if (nxt < 0)
				nxt = 0;
			if (nxt > longint'({AVG_W{1'b1}}))
				nxt = longint'({AVG_W{1'b1}});
			avg_q16 = nxt[AVG_W-1:0];
		end
		st.average_q = avg_q16;
		st.in_dip = dip_active;
		st.window_dips = dips_in_window;
		st.last_window_dips = dips_latched;
		st.window_samples = samples_in_window;
		st.total_samples = samples_total;
		due_status.push_back(st);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	// Driver: a new transaction goes out at the falling edge once the previous one has
	// been taken. Valid only ever drops when the sender decides to idle, never because
	// of the stall, and a stalled payload is left alone.
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_taken)) begin
			if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item <= item_backlog.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off that lets the block fill up
	// while the driver keeps offering transactions.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			result_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: both channels are sampled at the rising edge, before the block's
	// registers move.
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			item_taken <= item_valid && !item_stall;
			if (item_valid && !item_stall) begin
				predict_status(item);
				accepted_cnt++;
			end
			if (result_valid && !result_stall) begin
				if (due_status.size() == 0) begin
					$display("%0t unexpected result: expected none actual %h", $time, result);
					fail_cnt++;
				end else begin
					want = due_status.pop_front();
					check_field("average_q", want.average_q, result.average_q);
					check_field("in_dip", want.in_dip, result.in_dip);
					check_field("window_dips", want.window_dips, result.window_dips);
					check_field("last_window_dips", want.last_window_dips,
						result.last_window_dips);
					check_field("window_samples", want.window_samples, result.window_samples);
					check_field("total_samples", want.total_samples, result.total_samples);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic void add_sample(input logic [ADC_BITS-1:0] code);
		item_t it;
		it.op = OP_SAMPLE;
		it.sample = code;
		batch.push_back(it);
	endfunction

	// The sample field of a tick is don't-care, so it carries random bits.
	function automatic void add_tick();
		item_t it;
		it.op = OP_TICK;
		it.sample = ADC_BITS'($urandom);
		batch.push_back(it);
	endfunction

	// Register writes happen only while nothing is in flight, so the local copy of the
	// configuration can follow the write at the same edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ALPHA:          alpha_w = data[ALPHA_BITS-1:0];
			CFG_DIP_MARGIN:     dip_margin_w = data[MARGIN_BITS-1:0];
			CFG_RECOVER_MARGIN: recover_margin_w = data[MARGIN_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input int alpha_v, input int dip_v, input int rec_v);
		write_reg(CFG_ALPHA, CFG_DATA_W'(alpha_v));
		write_reg(CFG_DIP_MARGIN, CFG_DATA_W'(dip_v));
		write_reg(CFG_RECOVER_MARGIN, CFG_DATA_W'(rec_v));
	endtask

	// Random traffic shaped like a light signal: a level that wanders now and then,
	// samples close to it, drops deep enough to start a dip, and some plain noise.
	task automatic add_random(input int n);
		int level;
		int v;
		int r;
		level = $urandom_range(4095);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 6) begin
				add_tick();
			end else if (r < 12) begin
				add_sample(ADC_BITS'($urandom));
			end else begin
				if ($urandom_range(15) == 0)
					level = $urandom_range(4095);
				if (r < 32)
					v = level - int'(dip_margin_w) - $urandom_range(1, 200);
				else
					v = level + $urandom_range(0, 60) - 30;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
				add_sample(ADC_BITS'(v));
			end
		end
	endtask

	// Hands the staged batch to the driver under the given idling, then waits until
	// every transaction has been accepted and every result has come back.
	task automatic play(input int send_pct, input int recv_pct, input bit hold);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		hold_req = hold;
		foreach (batch[i])
			item_backlog.push_back(batch[i]);
		queued_cnt += batch.size();
		batch.delete();
		do @(negedge clk); while (accepted_cnt != queued_cnt || due_status.size() != 0);
	endtask

	initial begin : stimulus
		int dm;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values of the registers first.
		add_sample(12'h000);
		add_sample(12'hFFF);
		add_tick();
		add_sample(12'hFFF);
		play(0, 0, 1'b0);

		// Largest alpha and zero margins: the average follows the sample almost fully
		// and any step down starts a dip. The upper data bits of the margin writes
		// are set to show that they are dropped.
		set_regs(65535, 16'hF000, 16'hF000);
		add_sample(12'hFFF);
		add_sample(12'h000);
		add_sample(12'h000);
		add_sample(12'hFFF);
		add_sample(12'hFFF);
		add_tick();
		add_sample(12'h000);
		add_sample(12'hFFF);
		add_tick();
		play(0, 0, 1'b0);

		// Smallest nonzero alpha with the widest margins.
		set_regs(1, 4095, 4095);
		add_sample(12'hFFF);
		add_sample(12'h000);
		add_tick();
		play(0, 0, 1'b0);

		// Zero alpha freezes the average; the write to the unused index is ignored.
		write_reg(CFG_ALPHA, '0);
		write_reg(CFG_UNUSED, '1);
		add_sample(12'hFFF);
		add_sample(12'h000);
		add_sample(12'h001);
		play(0, 0, 1'b0);

		// A dip that starts on a deep drop and ends on the next, higher sample.
		set_regs(32768, 100, 40);
		add_sample(12'd4000);
		add_sample(12'd4000);
		add_sample(12'd4000);
		add_sample(12'd3700);
		add_sample(12'd3850);
		add_sample(12'd4000);
		play(0, 0, 1'b0);

		// Random phases. The first one also carries the long receiver hold-off.
		dm = $urandom_range(50, 300);
		set_regs(20000, dm, $urandom_range(0, dm));
		add_random(100);
		play(0, 0, 1'b1);

		dm = $urandom_range(0, 200);
		set_regs(65535, dm, $urandom_range(0, dm));
		add_random(100);
		play(77, 0, 1'b0);

		dm = $urandom_range(0, 4095);
		set_regs($urandom_range(1, 65535), dm, $urandom_range(0, 4095));
		add_random(100);
		play(0, 77, 1'b0);

		dm = $urandom_range(0, 400);
		set_regs(4000, dm, $urandom_range(0, dm));
		add_random(100);
		play(29, 29, 1'b0);

		// Full-scale swings with zero margins: every pair of samples starts one dip,
		// and the tick latches the window's dip count.
		set_regs(65535, 0, 0);
		repeat (DIP_PAIRS) begin
			add_sample(12'hFFF);
			add_sample(12'h000);
		end
		add_tick();
		add_sample(12'hFFF);
		play(0, 0, 1'b0);

		// Give any stray result time to show up before the verdict.
		repeat (8) @(negedge clk);
		if (fail_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/edd_pkg.sv
src/edd_cfg.sv
src/edd_core.sv
src/ema_dip_detector.sv
sim/tb.sv
